// File: src/spd_pkg.sv
package spd_pkg;

    typedef enum logic [2:0] {
        PH_AWAIT,
        PH_HEADER,
        PH_PAYLOAD,
        PH_SUBHDR,
        PH_SKIP
    } t_phase;

    typedef enum logic [2:0] {
        CLS_EEG,
        CLS_MOTION,
        CLS_OPTICS,
        CLS_BATTERY,
        CLS_SILENT
    } t_cls;

    localparam logic [2:0] KIND_EEG     = 3'd0;
    localparam logic [2:0] KIND_ACCEL   = 3'd1;
    localparam logic [2:0] KIND_GYRO    = 3'd2;
    localparam logic [2:0] KIND_OPTICS  = 3'd3;
    localparam logic [2:0] KIND_BATTERY = 3'd4;
    localparam logic [2:0] KIND_ERROR   = 3'd5;

    localparam logic ERR_SHORT_TAIL = 1'b0;
    localparam logic ERR_BAD_LENGTH = 1'b1;

    localparam logic [7:0] TAG_EEG4     = 8'h11;
    localparam logic [7:0] TAG_EEG8     = 8'h12;
    localparam logic [7:0] TAG_OPTICS4  = 8'h34;
    localparam logic [7:0] TAG_OPTICS8  = 8'h35;
    localparam logic [7:0] TAG_OPTICS16 = 8'h36;
    localparam logic [7:0] TAG_MOTION   = 8'h47;
    localparam logic [7:0] TAG_SILENT   = 8'h53;
    localparam logic [7:0] TAG_BATT_A   = 8'h88;
    localparam logic [7:0] TAG_BATT_B   = 8'h98;

    localparam logic [5:0] EEG_BITS    = 6'd14;
    localparam logic [5:0] OPTICS_BITS = 6'd20;
    localparam logic [5:0] WORD_BITS   = 6'd16;

    typedef struct packed {
        logic       hit;
        t_cls       cls;
        logic [5:0] len;
        logic [3:0] ch_mask;
        logic [2:0] ch_sh;
        logic [4:0] total;
    } t_blk_info;

    typedef struct packed {
        logic [2:0]  kind;
        logic [23:0] package_number;
        logic [2:0]  sample_pos;
        logic [3:0]  channel_index;
        logic [20:0] sample_value;
        logic        sample_done;
        logic        error_code;
    } t_result;

    function automatic t_blk_info blk_lookup(input logic [7:0] tag);
        t_blk_info b;
        b = '{hit: 1'b1, cls: CLS_SILENT, len: 6'd0, ch_mask: 4'd0, ch_sh: 3'd0,
              total: 5'd0};
        case (tag)
            TAG_EEG4: begin
                b.cls = CLS_EEG;     b.len = 6'd28; b.ch_mask = 4'd3;
                b.ch_sh = 3'd2;      b.total = 5'd16;
            end
            TAG_EEG8: begin
                b.cls = CLS_EEG;     b.len = 6'd28; b.ch_mask = 4'd7;
                b.ch_sh = 3'd3;      b.total = 5'd16;
            end
            TAG_OPTICS4: begin
                b.cls = CLS_OPTICS;  b.len = 6'd30; b.ch_mask = 4'd3;
                b.ch_sh = 3'd2;      b.total = 5'd12;
            end
            TAG_OPTICS8: begin
                b.cls = CLS_OPTICS;  b.len = 6'd40; b.ch_mask = 4'd7;
                b.ch_sh = 3'd3;      b.total = 5'd16;
            end
            TAG_OPTICS16: begin
                b.cls = CLS_OPTICS;  b.len = 6'd40; b.ch_mask = 4'd15;
                b.ch_sh = 3'd4;      b.total = 5'd16;
            end
            TAG_MOTION: begin
                b.cls = CLS_MOTION;  b.len = 6'd36; b.total = 5'd18;
            end
            TAG_SILENT: begin
                b.cls = CLS_SILENT;  b.len = 6'd24;
            end
            TAG_BATT_A, TAG_BATT_B: begin
                b.cls = CLS_BATTERY; b.len = 6'd20; b.total = 5'd1;
            end
            default: begin
                b.hit = 1'b0;
            end
        endcase
        return b;
    endfunction

endpackage

// File: src/spd_parser.sv
module spd_parser #(
    parameter int PKT_HEADER_BYTES = 14,
    parameter int SUB_HEADER_BYTES = 5,
    parameter int MAX_NOTIFY_BYTES = 512
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [7:0]       i_byte,
    input  logic [9:0]       i_left,
    output logic             o_res_valid,
    output spd_pkg::t_result o_res
);

    localparam int MaxW  = $clog2(MAX_NOTIFY_BYTES + 1);
    localparam int LeftW = (MaxW > 10) ? MaxW : 10;

    spd_pkg::t_phase r_phase, n_phase;
    logic        r_stopped, n_stopped;
    logic [7:0]  r_pkt_rem, n_pkt_rem;
    logic [4:0]  r_hdr_pos, n_hdr_pos;
    logic [15:0] r_pkt_num, n_pkt_num;
    logic [7:0]  r_tag, n_tag;
    logic [7:0]  r_blk_num, n_blk_num;
    logic [5:0]  r_pay_rem, n_pay_rem;
    logic [26:0] r_bit_buf, n_bit_buf;
    logic [4:0]  r_bit_fill, n_bit_fill;
    logic [4:0]  r_val_cnt, n_val_cnt;

    spd_pkg::t_blk_info blk;
    logic [LeftW-1:0]   left_s;
    logic [LeftW-1:0]   byte_ext;
    logic [5:0]         pos_next;
    logic [26:0]        buf_or;
    logic [5:0]         fill_add;
    logic [5:0]         width;
    logic [19:0]        raw;
    logic [26:0]        buf_shr;
    logic [4:0]         cnt;
    logic [2:0]         mot_smp;
    logic [4:0]         mot_c;
    logic [5:0]         pay_dec;

    assign blk = spd_pkg::blk_lookup(r_tag);

    always_comb begin
        left_s = LeftW'(i_left);
        if (i_left == 10'd0) begin
            left_s = LeftW'(1);
        end else if (left_s > LeftW'(MAX_NOTIFY_BYTES)) begin
            left_s = LeftW'(MAX_NOTIFY_BYTES);
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_stopped  = r_stopped;
        n_pkt_rem  = r_pkt_rem;
        n_hdr_pos  = r_hdr_pos;
        n_pkt_num  = r_pkt_num;
        n_tag      = r_tag;
        n_blk_num  = r_blk_num;
        n_pay_rem  = r_pay_rem;
        n_bit_buf  = r_bit_buf;
        n_bit_fill = r_bit_fill;
        n_val_cnt  = r_val_cnt;
        o_res_valid = 1'b0;
        o_res       = '0;
        byte_ext = LeftW'(i_byte);
        pos_next = {1'b0, r_hdr_pos} + 6'd1;
        buf_or   = r_bit_buf | (27'(i_byte) << r_bit_fill);
        fill_add = {1'b0, r_bit_fill} + 6'd8;
        cnt      = r_val_cnt;
        pay_dec  = (r_pay_rem != 6'd0) ? r_pay_rem - 6'd1 : r_pay_rem;
        width    = spd_pkg::WORD_BITS;
        raw      = 20'(buf_or[15:0]);
        buf_shr  = buf_or >> 16;
        unique case (blk.cls)
            spd_pkg::CLS_EEG: begin
                width   = spd_pkg::EEG_BITS;
                raw     = 20'(buf_or[13:0]);
                buf_shr = buf_or >> 14;
            end
            spd_pkg::CLS_OPTICS: begin
                width   = spd_pkg::OPTICS_BITS;
                raw     = buf_or[19:0];
                buf_shr = buf_or >> 20;
            end
            default: begin
            end
        endcase
        // motion: six values per sample, split accel / gyro
        if (cnt >= 5'd12) begin
            mot_smp = 3'd2;
            mot_c   = cnt - 5'd12;
        end else if (cnt >= 5'd6) begin
            mot_smp = 3'd1;
            mot_c   = cnt - 5'd6;
        end else begin
            mot_smp = 3'd0;
            mot_c   = cnt;
        end

        if (i_step && !r_stopped) begin
            if (r_phase != spd_pkg::PH_AWAIT && r_pkt_rem != 8'd0) begin
                n_pkt_rem = r_pkt_rem - 8'd1;
            end
            unique case (r_phase)
                spd_pkg::PH_AWAIT: begin
                    if (left_s < LeftW'(PKT_HEADER_BYTES)) begin
                        o_res_valid      = 1'b1;
                        o_res.kind       = spd_pkg::KIND_ERROR;
                        o_res.error_code = spd_pkg::ERR_SHORT_TAIL;
                        n_stopped        = 1'b1;
                    end else if (byte_ext < LeftW'(PKT_HEADER_BYTES) || byte_ext > left_s) begin
                        o_res_valid      = 1'b1;
                        o_res.kind       = spd_pkg::KIND_ERROR;
                        o_res.error_code = spd_pkg::ERR_BAD_LENGTH;
                        n_stopped        = 1'b1;
                    end else begin
                        n_pkt_rem = i_byte - 8'd1;
                        n_hdr_pos = 5'd1;
                        n_phase   = spd_pkg::PH_HEADER;
                    end
                end
                spd_pkg::PH_HEADER, spd_pkg::PH_SUBHDR: begin
                    if (r_phase == spd_pkg::PH_HEADER) begin
                        case (r_hdr_pos)
                            5'd1:    n_pkt_num[7:0]  = i_byte;
                            5'd2:    n_pkt_num[15:8] = i_byte;
                            5'd9:    n_tag           = i_byte;
                            5'd10:   n_blk_num       = i_byte;
                            default: begin
                            end
                        endcase
                    end else begin
                        case (r_hdr_pos)
                            5'd0:    n_tag     = i_byte;
                            5'd1:    n_blk_num = i_byte;
                            default: begin
                            end
                        endcase
                    end
                    if ((r_phase == spd_pkg::PH_HEADER && pos_next >= 6'(PKT_HEADER_BYTES)) ||
                        (r_phase == spd_pkg::PH_SUBHDR && pos_next >= 6'(SUB_HEADER_BYTES))) begin
                        // open the block only if it fits in what is left of the packet
                        if (blk.hit && 8'(blk.len) <= n_pkt_rem) begin
                            n_phase    = spd_pkg::PH_PAYLOAD;
                            n_pay_rem  = blk.len;
                            n_bit_buf  = '0;
                            n_bit_fill = '0;
                            n_val_cnt  = '0;
                        end else begin
                            n_phase = spd_pkg::PH_SKIP;
                        end
                    end else begin
                        n_hdr_pos = pos_next[4:0];
                    end
                end
                spd_pkg::PH_PAYLOAD: begin
                    if (blk.hit && blk.cls != spd_pkg::CLS_SILENT && r_val_cnt < blk.total) begin
                        n_bit_buf  = buf_or;
                        n_bit_fill = fill_add[4:0];
                        if (fill_add >= width) begin
                            n_bit_buf  = buf_shr;
                            n_bit_fill = 5'(fill_add - width);
                            n_val_cnt  = r_val_cnt + 5'd1;
                            o_res_valid          = 1'b1;
                            o_res.package_number = {r_pkt_num, r_blk_num};
                            unique case (blk.cls)
                                spd_pkg::CLS_MOTION: begin
                                    o_res.kind = (mot_c < 5'd3) ? spd_pkg::KIND_ACCEL
                                                                : spd_pkg::KIND_GYRO;
                                    o_res.sample_pos    = mot_smp;
                                    o_res.channel_index = (mot_c >= 5'd3) ? 4'(mot_c - 5'd3)
                                                                          : 4'(mot_c);
                                    o_res.sample_value  = {{5{raw[15]}}, raw[15:0]};
                                    o_res.sample_done   = (mot_c == 5'd5);
                                end
                                spd_pkg::CLS_BATTERY: begin
                                    o_res.kind         = spd_pkg::KIND_BATTERY;
                                    o_res.sample_value = 21'(raw[15:0]);
                                    o_res.sample_done  = 1'b1;
                                end
                                default: begin
                                    o_res.kind = (blk.cls == spd_pkg::CLS_EEG)
                                                 ? spd_pkg::KIND_EEG : spd_pkg::KIND_OPTICS;
                                    o_res.sample_pos    = 3'(cnt >> blk.ch_sh);
                                    o_res.channel_index = cnt[3:0] & blk.ch_mask;
                                    o_res.sample_value  = 21'(raw);
                                    o_res.sample_done   = ((cnt[3:0] & blk.ch_mask)
                                                           == blk.ch_mask);
                                end
                            endcase
                        end
                    end
                    n_pay_rem = pay_dec;
                    if (pay_dec == 6'd0) begin
                        if (n_pkt_rem >= 8'(SUB_HEADER_BYTES)) begin
                            n_phase   = spd_pkg::PH_SUBHDR;
                            n_hdr_pos = 5'd0;
                        end else begin
                            n_phase = spd_pkg::PH_SKIP;
                        end
                    end
                end
                spd_pkg::PH_SKIP: begin
                end
                default: begin
                    n_phase = spd_pkg::PH_AWAIT;
                end
            endcase
            if (n_phase != spd_pkg::PH_AWAIT && n_pkt_rem == 8'd0) begin
                n_phase = spd_pkg::PH_AWAIT;
            end
        end

        // last byte of the notification: rearm for the next one
        if (i_step && left_s == LeftW'(1)) begin
            n_stopped = 1'b0;
            n_phase   = spd_pkg::PH_AWAIT;
            n_pkt_rem = '0;
            n_hdr_pos = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= spd_pkg::PH_AWAIT;
            r_stopped  <= 1'b0;
            r_pkt_rem  <= '0;
            r_hdr_pos  <= '0;
            r_pkt_num  <= '0;
            r_tag      <= '0;
            r_blk_num  <= '0;
            r_pay_rem  <= '0;
            r_bit_buf  <= '0;
            r_bit_fill <= '0;
            r_val_cnt  <= '0;
        end else begin
            r_phase    <= n_phase;
            r_stopped  <= n_stopped;
            r_pkt_rem  <= n_pkt_rem;
            r_hdr_pos  <= n_hdr_pos;
            r_pkt_num  <= n_pkt_num;
            r_tag      <= n_tag;
            r_blk_num  <= n_blk_num;
            r_pay_rem  <= n_pay_rem;
            r_bit_buf  <= n_bit_buf;
            r_bit_fill <= n_bit_fill;
            r_val_cnt  <= n_val_cnt;
        end
    end

endmodule

// File: src/sensor_packet_deframer.sv
// Sensor packet deframer: takes one notification byte per transaction together with the
// count of bytes left in the notification (this one included, 1 marks the last), cuts the
// notification into length-prefixed packets, walks the primary block and its subblocks and
// emits one raw sample value per transaction as each completes (EEG 14-bit, optics 20-bit,
// motion int16 split into accel and gyro, battery 16-bit), or an error event for a short
// tail or a bad packet length, after which the rest of the notification is dropped. A byte
// produces at most one result. The block sustains one byte per clock while the master side
// takes results: each byte is parsed combinationally from the input register into the
// result register, which presents it on the master side, and the per-byte parse step sets
// that rate. A result that waits on m_axis_tready holds the input register, and s_axis_tready
// drops once that register is also full.
module sensor_packet_deframer #(
    parameter int PKT_HEADER_BYTES = 14,
    parameter int SUB_HEADER_BYTES = 5,
    parameter int MAX_NOTIFY_BYTES = 512
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // byte_value[7:0], bytes_left[17:8], zero pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // package_number[23:0], sample_pos[26:24],
                                        // channel_index[30:27], sample_value[51:31], pad
    output logic [3:0]  m_axis_tuser,   // kind[2:0], error_code[3]
    output logic        m_axis_tlast    // sample_done
);

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic [9:0]       r_in_left;
    logic             r_out_valid;
    spd_pkg::t_result r_out;

    logic             out_space;
    logic             advance;
    logic             res_valid;
    spd_pkg::t_result res;

    assign out_space     = !r_out_valid || m_axis_tready;
    assign advance       = r_in_valid && out_space;
    assign s_axis_tready = !r_in_valid || advance;

    spd_parser #(
        .PKT_HEADER_BYTES(PKT_HEADER_BYTES),
        .SUB_HEADER_BYTES(SUB_HEADER_BYTES),
        .MAX_NOTIFY_BYTES(MAX_NOTIFY_BYTES)
    ) u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (advance),
        .i_byte     (r_in_byte),
        .i_left     (r_in_left),
        .o_res_valid(res_valid),
        .o_res      (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= res_valid;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata[7:0];
            r_in_left <= s_axis_tdata[17:8];
        end
        // hold the result until the downstream transaction completes
        if (advance && res_valid) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'd0, r_out.sample_value, r_out.channel_index,
                            r_out.sample_pos, r_out.package_number};
    assign m_axis_tuser  = {r_out.error_code, r_out.kind};
    assign m_axis_tlast  = r_out.sample_done;

endmodule

// File: test/sensor_packet_deframer_tb.sv
`timescale 1ns / 100ps

module sensor_packet_deframer_tb;
    import spd_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 9;
    localparam int HDR_BYTES    = 14;
    localparam int SUB_BYTES    = 5;
    localparam int MAX_LEFT     = 512;
    localparam int RANDOM_BYTES = 1650;
    localparam int STALL_LIMIT  = 5000;
    localparam int TAIL_CYCLES  = 8;
    localparam int MAX_REPORTS  = 40;

    // byte offsets inside the packet header and the subblock header
    localparam int POS_IDX_LO   = 1;
    localparam int POS_IDX_HI   = 2;
    localparam int POS_TAG      = 9;
    localparam int POS_BNUM     = 10;
    localparam int SUB_POS_TAG  = 0;
    localparam int SUB_POS_BNUM = 1;

    typedef struct packed {
        logic [7:0] value;
        logic [9:0] left;
        logic       typed;
        t_result    res;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;   // byte_value[7:0], bytes_left[17:8], zero pad
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;   // package_number[23:0], sample_pos[26:24],
                                 // channel_index[30:27], sample_value[51:31], pad
    logic [3:0]  m_axis_tuser;   // kind[2:0], error_code[3]
    logic        m_axis_tlast;   // sample_done

    sensor_packet_deframer #(
        .PKT_HEADER_BYTES(HDR_BYTES),
        .SUB_HEADER_BYTES(SUB_BYTES),
        .MAX_NOTIFY_BYTES(MAX_LEFT)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    t_result    pending_samples[$];
    t_stim_row  stim_rows[$];
    logic [7:0] note_bytes[$];
    logic       drive_typed;
    t_result    drive_typed_res;
    int         tx_idle_pct;
    int         rx_idle_pct;
    int         bytes_sent;
    int         fail_count   = 0;
    int         stall_cycles = 0;

    // deframer state as the predictor sees it
    logic        p_stopped  = 1'b0;
    t_phase      p_phase    = PH_AWAIT;
    logic [7:0]  p_pkt_left = '0;
    logic [4:0]  p_hdr_pos  = '0;
    logic [15:0] p_pkt_idx  = '0;
    logic [7:0]  p_tag      = '0;
    logic [7:0]  p_bnum     = '0;
    logic [5:0]  p_pay_left = '0;
    logic [26:0] p_bits     = '0;
    logic [4:0]  p_fill     = '0;
    logic [4:0]  p_count    = '0;

    function automatic logic blk_shape(input logic [7:0] tag, output t_cls cls,
                                       output logic [5:0] len, output logic [4:0] nch,
                                       output logic [4:0] total);
        logic known;
        known = 1'b1;
        cls   = CLS_SILENT;
        len   = '0;
        nch   = '0;
        total = '0;
        case (tag)
            TAG_EEG4: begin
                cls = CLS_EEG;     len = 6'd28; nch = 5'd4;  total = 5'd16;
            end
            TAG_EEG8: begin
                cls = CLS_EEG;     len = 6'd28; nch = 5'd8;  total = 5'd16;
            end
            TAG_OPTICS4: begin
                cls = CLS_OPTICS;  len = 6'd30; nch = 5'd4;  total = 5'd12;
            end
            TAG_OPTICS8: begin
                cls = CLS_OPTICS;  len = 6'd40; nch = 5'd8;  total = 5'd16;
            end
            TAG_OPTICS16: begin
                cls = CLS_OPTICS;  len = 6'd40; nch = 5'd16; total = 5'd16;
            end
            TAG_MOTION: begin
                cls = CLS_MOTION;  len = 6'd36; nch = 5'd6;  total = 5'd18;
            end
            TAG_SILENT: begin
                cls = CLS_SILENT;  len = 6'd24; nch = 5'd2;  total = 5'd0;
            end
            TAG_BATT_A, TAG_BATT_B: begin
                cls = CLS_BATTERY; len = 6'd20; nch = 5'd1;  total = 5'd1;
            end
            default: known = 1'b0;
        endcase
        return known;
    endfunction

    task automatic open_block();
        t_cls       cls;
        logic [5:0] len;
        logic [4:0] nch;
        logic [4:0] total;
        if (blk_shape(p_tag, cls, len, nch, total) && len <= p_pkt_left) begin
            p_phase    = PH_PAYLOAD;
            p_pay_left = len;
            p_bits     = '0;
            p_fill     = '0;
            p_count    = '0;
        end else begin
            p_phase = PH_SKIP;
        end
    endtask

    task automatic unpack_value(input logic [7:0] b, output logic hit, output t_result r);
        t_cls        cls;
        logic [5:0]  len;
        logic [4:0]  nch;
        logic [4:0]  total;
        logic [5:0]  width;
        logic [20:0] raw;
        logic [4:0]  cnt;
        logic [4:0]  ch;
        hit = 1'b0;
        r   = '0;
        if (blk_shape(p_tag, cls, len, nch, total) && cls != CLS_SILENT && p_count < total)
        begin
            width  = (cls == CLS_EEG) ? EEG_BITS : (cls == CLS_OPTICS) ? OPTICS_BITS : WORD_BITS;
            p_bits = p_bits | (27'(b) << p_fill);
            p_fill = p_fill + 5'd8;
            if (p_fill >= width) begin
                raw     = 21'(p_bits & ((27'd1 << width) - 27'd1));
                p_bits  = p_bits >> width;
                p_fill  = p_fill - 5'(width);
                cnt     = p_count;
                p_count = p_count + 5'd1;
                hit     = 1'b1;
                r.package_number = {p_pkt_idx, p_bnum};
                case (cls)
                    CLS_MOTION: begin
                        ch = 5'(cnt % 6);
                        if (raw[15]) raw[20:16] = '1;
                        r.kind          = (ch < 3) ? KIND_ACCEL : KIND_GYRO;
                        r.sample_pos    = 3'(cnt / 6);
                        r.channel_index = 4'(ch % 3);
                        r.sample_done   = (ch == 5);
                    end
                    CLS_BATTERY: begin
                        r.kind        = KIND_BATTERY;
                        r.sample_done = 1'b1;
                    end
                    default: begin
                        ch = cnt % nch;
                        r.kind          = (cls == CLS_EEG) ? KIND_EEG : KIND_OPTICS;
                        r.sample_pos    = 3'(cnt / nch);
                        r.channel_index = 4'(ch);
                        r.sample_done   = (ch == nch - 1);
                    end
                endcase
                r.sample_value = raw;
            end
        end
    endtask

    // advance the predicted deframer by one byte
    task automatic deframe_byte(input logic [7:0] b, input logic [9:0] left_in,
                                output logic hit, output t_result r);
        int unsigned left;
        logic [4:0]  pos;
        hit  = 1'b0;
        r    = '0;
        left = left_in;
        if (left == 0) left = 1;
        if (left > MAX_LEFT) left = MAX_LEFT;
        if (!p_stopped) begin
            if (p_phase != PH_AWAIT && p_pkt_left != 0) p_pkt_left = p_pkt_left - 8'd1;
            case (p_phase)
                PH_AWAIT: begin
                    if (left < HDR_BYTES) begin
                        hit          = 1'b1;
                        r.kind       = KIND_ERROR;
                        r.error_code = ERR_SHORT_TAIL;
                        p_stopped    = 1'b1;
                    end else if (b < HDR_BYTES || b > left) begin
                        hit          = 1'b1;
                        r.kind       = KIND_ERROR;
                        r.error_code = ERR_BAD_LENGTH;
                        p_stopped    = 1'b1;
                    end else begin
                        p_pkt_left = b - 8'd1;
                        p_hdr_pos  = 5'd1;
                        p_phase    = PH_HEADER;
                    end
                end
                PH_HEADER: begin
                    pos = p_hdr_pos;
                    case (pos)
                        POS_IDX_LO: p_pkt_idx[7:0]  = b;
                        POS_IDX_HI: p_pkt_idx[15:8] = b;
                        POS_TAG:    p_tag           = b;
                        POS_BNUM:   p_bnum          = b;
                        default: ;
                    endcase
                    if (pos + 1 >= HDR_BYTES) open_block();
                    else p_hdr_pos = pos + 5'd1;
                end
                PH_PAYLOAD: begin
                    unpack_value(b, hit, r);
                    if (p_pay_left != 0) p_pay_left = p_pay_left - 6'd1;
                    if (p_pay_left == 0) begin
                        if (p_pkt_left >= SUB_BYTES) begin
                            p_phase   = PH_SUBHDR;
                            p_hdr_pos = '0;
                        end else begin
                            p_phase = PH_SKIP;
                        end
                    end
                end
                PH_SUBHDR: begin
                    pos = p_hdr_pos;
                    case (pos)
                        SUB_POS_TAG:  p_tag  = b;
                        SUB_POS_BNUM: p_bnum = b;
                        default: ;
                    endcase
                    if (pos + 1 >= SUB_BYTES) open_block();
                    else p_hdr_pos = pos + 5'd1;
                end
                PH_SKIP: ;
                default: p_phase = PH_AWAIT;
            endcase
            if (p_phase != PH_AWAIT && p_pkt_left == 0) p_phase = PH_AWAIT;
        end
        // end of notification: rearm for the next one
        if (left == 1) begin
            p_stopped  = 1'b0;
            p_phase    = PH_AWAIT;
            p_pkt_left = '0;
            p_hdr_pos  = '0;
        end
    endtask

    function automatic t_result err_event(input logic code);
        t_result r;
        r            = '0;
        r.kind       = KIND_ERROR;
        r.error_code = code;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [23:0] want,
                                        input logic [23:0] got);
        if (want !== got) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endfunction

    function automatic logic [7:0] tag_at(input int i);
        case (i)
            0: return TAG_EEG4;
            1: return TAG_EEG8;
            2: return TAG_OPTICS4;
            3: return TAG_OPTICS8;
            4: return TAG_OPTICS16;
            5: return TAG_MOTION;
            6: return TAG_SILENT;
            7: return TAG_BATT_A;
            default: return TAG_BATT_B;
        endcase
    endfunction

    function automatic logic [7:0] pick_tag();
        if ($urandom_range(99) < 88) return tag_at($urandom_range(8));
        return 8'($urandom);
    endfunction

    always @(negedge i_clk) m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);

    always @(posedge i_clk) begin : scoreboard
        logic    hit;
        t_result want;
        t_result got;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                deframe_byte(s_axis_tdata[7:0], s_axis_tdata[17:8], hit, want);
                if (drive_typed)
                    pending_samples.insert(pending_samples.size(), drive_typed_res);
                else if (hit)
                    pending_samples.insert(pending_samples.size(), want);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.kind           = m_axis_tuser[2:0];
                got.error_code     = m_axis_tuser[3];
                got.package_number = m_axis_tdata[23:0];
                got.sample_pos     = m_axis_tdata[26:24];
                got.channel_index  = m_axis_tdata[30:27];
                got.sample_value   = m_axis_tdata[51:31];
                got.sample_done    = m_axis_tlast;
                if (pending_samples.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t: unexpected result, expected none, actual %0h",
                                 $time, got);
                end else begin
                    want = pending_samples.pop_front();
                    check_field("kind", 24'(want.kind), 24'(got.kind));
                    check_field("package_number", want.package_number, got.package_number);
                    check_field("sample_pos", 24'(want.sample_pos), 24'(got.sample_pos));
                    check_field("channel_index", 24'(want.channel_index),
                                24'(got.channel_index));
                    check_field("sample_value", 24'(want.sample_value),
                                24'(got.sample_value));
                    check_field("sample_done", 24'(want.sample_done), 24'(got.sample_done));
                    check_field("error_code", 24'(want.error_code), 24'(got.error_code));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic table_row(input logic [7:0] value, input logic [9:0] left,
                             input logic typed, input t_result res);
        t_stim_row row;
        row.value = value;
        row.left  = left;
        row.typed = typed;
        row.res   = res;
        stim_rows.insert(stim_rows.size(), row);
    endtask

    task automatic send_byte(input logic [7:0] value, input logic [9:0] left,
                             input logic typed, input t_result res);
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid   = 1'b1;
        s_axis_tdata    = {6'd0, left, value};
        drive_typed     = typed;
        drive_typed_res = res;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic hold_until_drained();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending_samples.size() != 0) @(posedge i_clk);
    endtask

    task automatic add_packet(input logic force_tag, input logic [7:0] forced);
        logic [7:0] pkt[$];
        logic [15:0] idx;
        logic [7:0]  tag;
        t_cls        cls;
        logic [5:0]  len;
        logic [4:0]  nch;
        logic [4:0]  total;
        int          body;
        int          nsub;
        int          flaw;
        tag = force_tag ? forced : pick_tag();
        idx = 16'($urandom);
        pkt.insert(pkt.size(), 8'd0);
        pkt.insert(pkt.size(), idx[7:0]);
        pkt.insert(pkt.size(), idx[15:8]);
        repeat (6) pkt.insert(pkt.size(), 8'($urandom));
        pkt.insert(pkt.size(), tag);
        pkt.insert(pkt.size(), 8'($urandom));
        repeat (3) pkt.insert(pkt.size(), 8'($urandom));
        if (blk_shape(tag, cls, len, nch, total)) body = len;
        else body = $urandom_range(0, 12);
        repeat (body) pkt.insert(pkt.size(), 8'($urandom));
        nsub = ($urandom_range(9) == 0) ? 3 : $urandom_range(0, 2);
        repeat (nsub) begin
            tag = pick_tag();
            pkt.insert(pkt.size(), tag);
            repeat (SUB_BYTES - 1) pkt.insert(pkt.size(), 8'($urandom));
            if (blk_shape(tag, cls, len, nch, total)) body = len;
            else body = $urandom_range(0, 12);
            repeat (body) pkt.insert(pkt.size(), 8'($urandom));
        end
        flaw = force_tag ? 0 : $urandom_range(1, 20);
        if (flaw == 1) begin
            // short trailer: too few bytes for another subblock header
            repeat ($urandom_range(1, SUB_BYTES - 1)) pkt.insert(pkt.size(), 8'($urandom));
        end else if (flaw == 2) begin
            repeat ($urandom_range(1, 20)) if (pkt.size() > 1) void'(pkt.pop_back());
        end
        pkt[0] = 8'(pkt.size());
        if (flaw == 3) pkt[0] = 8'($urandom);
        else if (flaw == 4) pkt[0] = 8'(pkt.size() + $urandom_range(1, 8));
        foreach (pkt[k]) note_bytes.insert(note_bytes.size(), pkt[k]);
    endtask

    // sweep_idx >= 0 forces the primary tag and keeps the notification clean
    task automatic send_notification(input int sweep_idx, input logic make_long);
        int         n;
        int         dice;
        logic [9:0] left;
        logic [7:0] value;
        note_bytes.delete();
        if (sweep_idx >= 0) begin
            add_packet(1'b1, (sweep_idx < 9) ? tag_at(sweep_idx) : 8'h00);
        end else begin
            repeat ($urandom_range(1, 2)) add_packet(1'b0, 8'h00);
            // a long notification drives bytes_left past saturation
            if (make_long)
                while (note_bytes.size() < MAX_LEFT + 48) add_packet(1'b0, 8'h00);
            if ($urandom_range(9) == 0)
                repeat ($urandom_range(1, HDR_BYTES - 1))
                    note_bytes.insert(note_bytes.size(), 8'($urandom));
        end
        n = note_bytes.size();
        for (int i = 0; i < n; i++) begin
            left  = 10'(n - i);
            value = note_bytes[i];
            dice  = $urandom_range(99);
            if (sweep_idx < 0 && dice < 2) left = 10'($urandom_range(0, 1023));
            else if (sweep_idx < 0 && dice < 4) value = 8'($urandom);
            send_byte(value, left, 1'b0, '0);
        end
    endtask

    initial begin
        int   quota;
        int   sweep;
        logic long_sent;
        i_rst_n         = 1'b0;
        s_axis_tvalid   = 1'b0;
        s_axis_tdata    = '0;
        drive_typed     = 1'b0;
        drive_typed_res = '0;
        tx_idle_pct     = 11;
        rx_idle_pct     = 80;
        bytes_sent      = 0;
        sweep           = 0;
        long_sent       = 1'b0;

        table_row(8'h00, 10'd1,    1'b1, err_event(ERR_SHORT_TAIL));
        table_row(8'hFF, 10'd0,    1'b1, err_event(ERR_SHORT_TAIL));
        table_row(8'h0D, 10'd20,   1'b1, err_event(ERR_BAD_LENGTH));
        table_row(8'hAA, 10'd19,   1'b0, '0);
        table_row(8'h55, 10'd1,    1'b0, '0);
        table_row(8'h15, 10'd20,   1'b1, err_event(ERR_BAD_LENGTH));
        table_row(8'h00, 10'd1,    1'b0, '0);
        table_row(8'hFF, 10'd1023, 1'b0, '0);
        table_row(8'h01, 10'd1,    1'b0, '0);
        table_row(8'hFF, 10'd13,   1'b1, err_event(ERR_SHORT_TAIL));
        table_row(8'h00, 10'd1,    1'b0, '0);
        // minimum packet: header only, so the primary block does not fit
        table_row(8'h0E, 10'd14, 1'b0, '0);
        table_row(8'hFF, 10'd13, 1'b0, '0);
        table_row(8'h80, 10'd12, 1'b0, '0);
        table_row(8'h00, 10'd11, 1'b0, '0);
        table_row(8'h00, 10'd10, 1'b0, '0);
        table_row(8'h00, 10'd9,  1'b0, '0);
        table_row(8'h00, 10'd8,  1'b0, '0);
        table_row(8'h00, 10'd7,  1'b0, '0);
        table_row(8'h00, 10'd6,  1'b0, '0);
        table_row(TAG_EEG4, 10'd5, 1'b0, '0);
        table_row(8'hFF, 10'd4,  1'b0, '0);
        table_row(8'h00, 10'd3,  1'b0, '0);
        table_row(8'h00, 10'd2,  1'b0, '0);
        table_row(8'h00, 10'd1,  1'b0, '0);

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (stim_rows[i])
            send_byte(stim_rows[i].value, stim_rows[i].left, stim_rows[i].typed,
                      stim_rows[i].res);

        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin tx_idle_pct = 11; rx_idle_pct = 80; end
                1: begin tx_idle_pct = 80; rx_idle_pct = 11; end
                default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
            endcase
            // running target, so an overshoot in one phase shortens the next
            quota = stim_rows.size() + RANDOM_BYTES * (ph + 1) / 3;
            while (bytes_sent < quota) begin
                if (sweep < 10) begin
                    send_notification(sweep, 1'b0);
                    sweep++;
                end else if (ph == 1 && !long_sent) begin
                    send_notification(-1, 1'b1);
                    long_sent = 1'b1;
                end else begin
                    send_notification(-1, 1'b0);
                end
            end
            // hold the sender until every pending result is out
            hold_until_drained();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
